// ===== src/rgblab_pkg.sv =====
// Shared types, constants and the linearization table for the RGB to L*a*b* converter.
package rgblab_pkg;

    localparam int LANES       = 3;
    localparam int CHAN_W      = 8;
    localparam int LIN_W       = 29;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 45;
    localparam int T_W         = 29;
    localparam int REM_W       = 61;
    localparam int ROOT_W      = 21;
    localparam int YSQ_W       = 42;
    localparam int CBRT_STEPS  = 21;
    localparam int WORK_FRAC   = 20;
    localparam int LINF_W      = 17;
    localparam int LLIN_W      = 24;
    localparam int SIDE_W      = LANES + LANES * LINF_W + LLIN_W;
    localparam int LAB_W       = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [T_W-1:0] CUBE_THRESHOLD = 29'd2377264;
    localparam logic [18:0]    LINF_SLOPE     = 19'd510329;
    localparam logic [ROOT_W-1:0] LINF_OFFSET = 21'd144631;
    localparam logic [25:0]    L_SLOPE        = 26'd59198669;

    typedef logic [LANES-1:0][LANES-1:0][COEF_W-1:0] coef_mat_t;
    typedef logic [255:0][LIN_W-1:0] lin_tab_t;

    // White-normalized matrix, Q16, rows X, Y, Z and columns R, G, B.
    localparam coef_mat_t COEF = '{
        '{16'd57199, 16'd7173, 16'd1164},
        '{16'd4731, 16'd46868, 16'd13937},
        '{16'd12443, 16'd24656, 16'd28437}
    };

    // (v/255)^2.5 in Q28, built at elaboration.
    function automatic lin_tab_t build_lin_table();
        lin_tab_t tab;
        logic [63:0] v;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] c;
        for (int vi = 0; vi < 256; vi++)
        begin
            v = 64'(vi);
            n = (v << 56) / 64'd255;
            r = '0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c <= n)
                begin
                    r = c;
                end
            end
            tab[vi] = LIN_W'((v * v * r + 64'd32512) / 64'd65025);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

// ===== src/rgblab_cbrt.sv =====
// Pipelined bit-by-bit cube root for three lanes, one result bit per stage.
module rgblab_cbrt
    import rgblab_pkg::*;
#(
    parameter int SIDE_W_P = SIDE_W
)
(
    input  logic                               clk,
    input  logic [CBRT_STEPS-1:0]              en,
    input  logic [LANES-1:0][T_W-1:0]          t_in,
    input  logic [SIDE_W_P-1:0]                side_in,
    output logic [LANES-1:0][ROOT_W-1:0]       root,
    output logic [SIDE_W_P-1:0]                side_out
);

    logic [REM_W-1:0]  rem_reg  [CBRT_STEPS][LANES];
    logic [ROOT_W-1:0] y_reg    [CBRT_STEPS][LANES];
    logic [YSQ_W-1:0]  ysq_reg  [CBRT_STEPS][LANES];
    logic [SIDE_W_P-1:0] side_reg [CBRT_STEPS];

    genvar k, l;
    generate
        for (k = 0; k < CBRT_STEPS; k++)
        begin : g_step
            localparam int SH = 3 * (CBRT_STEPS - 1 - k);

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
                end
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [REM_W-1:0]  rem_in;
                logic [ROOT_W-1:0] y_in;
                logic [YSQ_W-1:0]  ysq_in;
                logic [ROOT_W-1:0] y2;
                logic [YSQ_W-1:0]  ysq2;
                logic [65:0]       bound;
                logic              take;
                logic [REM_W-1:0]  rem_next;
                logic [ROOT_W-1:0] y_next;
                logic [YSQ_W-1:0]  ysq_next;

                always_comb
                begin
                    if (k == 0)
                    begin
                        rem_in = {t_in[l], 32'b0};
                        y_in   = '0;
                        ysq_in = '0;
                    end
                    else
                    begin
                        rem_in = rem_reg[(k == 0) ? 0 : k - 1][l];
                        y_in   = y_reg[(k == 0) ? 0 : k - 1][l];
                        ysq_in = ysq_reg[(k == 0) ? 0 : k - 1][l];
                    end
                    y2    = {y_in[ROOT_W-2:0], 1'b0};
                    ysq2  = {ysq_in[YSQ_W-3:0], 2'b0};
                    // Cube of (2y+1) minus cube of 2y, scaled to this bit position.
                    bound = (66'(ysq2) * 66'd3 + 66'(y2) * 66'd3 + 66'd1) << SH;
                    take  = 66'(rem_in) >= bound;
                    if (take)
                    begin
                        rem_next = rem_in - bound[REM_W-1:0];
                        y_next   = y2 | ROOT_W'(1);
                        ysq_next = ysq2 + {y2, 1'b0} + YSQ_W'(1);
                    end
                    else
                    begin
                        rem_next = rem_in;
                        y_next   = y2;
                        ysq_next = ysq2;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        rem_reg[k][l] <= rem_next;
                        y_reg[k][l]   <= y_next;
                        ysq_reg[k][l] <= ysq_next;
                    end
                end
            end
        end

        for (l = 0; l < LANES; l++)
        begin : g_out
            assign root[l] = y_reg[CBRT_STEPS-1][l];
        end
    endgenerate

    assign side_out = side_reg[CBRT_STEPS-1];

endmodule

// ===== src/rgb_to_lab_converter.sv =====
// Top level of the streaming 8-bit RGB to CIE L*a*b* (D65) converter.
//
// One pixel enters per transaction on the slave channel (s_tvalid, s_tready,
// s_tdata) and one L*a*b* result leaves per transaction on the master channel
// (m_tvalid, m_tready, m_tdata). Results come out in input order, one for each
// pixel. All outputs carry FRAC_BITS fraction bits, rounded and saturated.
//
// The datapath is a 27-stage pipeline: table lookup, matrix products, matrix
// sums, 21 stages of bit-serial cube root (one root bit per stage, all three
// lanes side by side), branch select, L/a/b scaling, and rounding into the
// output register. Throughput is one pixel per clock while the receiver
// keeps m_tready high, set by the cube root pipeline.
//
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and new
// pixels keep entering until all 27 stages hold data. s_tready then drops.
// Nothing is lost or repeated across a stall.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
module rgb_to_lab_converter
    import rgblab_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // lightness [14:0], green_red [30:15],
                                   // blue_yellow [46:31], zero [47]
);

    localparam int STAGES   = 27;
    localparam int CB_FIRST = 3;
    localparam int ST_F     = CB_FIRST + CBRT_STEPS;
    localparam int ST_LAB   = ST_F + 1;
    localparam int ST_OUT   = ST_LAB + 1;
    localparam int SHIFT    = WORK_FRAC - FRAC_BITS;
    localparam int L_MAX    = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

    // Per-stage handshake: a stage loads when it is empty or its successor moves.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] en;

    assign rdy[STAGES] = m_tready;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_ctl
            assign rdy[g] = !valid_reg[g] || rdy[g+1];
            assign en[g]  = rdy[g];
            if (g == 0)
            begin : g_first
                assign valid_next[g] = en[g] ? s_tvalid : valid_reg[g];
            end
            else
            begin : g_rest
                assign valid_next[g] = en[g] ? valid_reg[g-1] : valid_reg[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[ST_OUT];

    // Stage 0: linearization lookup.
    logic [LANES-1:0][LIN_W-1:0] lin_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int c = 0; c < LANES; c++)
            begin
                lin_reg[c] <= LIN_TABLE[s_tdata[CHAN_W*c +: CHAN_W]];
            end
        end
    end

    // Stage 1: the nine matrix products.
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    prod_reg[i][j] <= PROD_W'(COEF[i][j]) * PROD_W'(lin_reg[j]);
                end
            end
        end
    end

    // Stage 2: row sums, rounded back to Q28.
    logic [LANES-1:0][T_W-1:0] t_reg;
    logic [LANES-1:0][T_W-1:0] t_next;

    always_comb
    begin
        logic [PROD_W:0] sum;
        for (int i = 0; i < LANES; i++)
        begin
            sum = (PROD_W+1)'(prod_reg[i][0]) + (PROD_W+1)'(prod_reg[i][1])
                + (PROD_W+1)'(prod_reg[i][2]) + (PROD_W+1)'(1 << 15);
            t_next[i] = sum[16 +: T_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t_reg <= t_next;
        end
    end

    // Linear-branch values travel beside the cube root.
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] side_out;
    logic [LANES-1:0][ROOT_W-1:0] root;

    always_comb
    begin
        logic [47:0] lf_prod;
        logic [55:0] ll_prod;
        side_in = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lf_prod = 48'(t_reg[i]) * 48'(LINF_SLOPE) + 48'(1 << 23);
            side_in[i] = t_reg[i] > CUBE_THRESHOLD;
            side_in[LANES + LINF_W*i +: LINF_W] = lf_prod[24 +: LINF_W];
        end
        ll_prod = 56'(t_reg[1]) * 56'(L_SLOPE) + 56'(1 << 23);
        side_in[LANES + LANES*LINF_W +: LLIN_W] = ll_prod[24 +: LLIN_W];
    end

    rgblab_cbrt #(
        .SIDE_W_P (SIDE_W)
    ) u_cbrt (
        .clk      (clk),
        .en       (en[CB_FIRST +: CBRT_STEPS]),
        .t_in     (t_reg),
        .side_in  (side_in),
        .root     (root),
        .side_out (side_out)
    );

    // Branch select for f(t).
    logic [LANES-1:0][ROOT_W-1:0] f_reg;
    logic                         flag_y_reg;
    logic [LLIN_W-1:0]            llin_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_F])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                f_reg[i] <= side_out[i] ? root[i]
                          : ROOT_W'(side_out[LANES + LINF_W*i +: LINF_W]) + LINF_OFFSET;
            end
            flag_y_reg <= side_out[1];
            llin_reg   <= side_out[LANES + LANES*LINF_W +: LLIN_W];
        end
    end

    // L, a and b in Q20.
    logic signed [LAB_W-1:0] l_reg;
    logic signed [LAB_W-1:0] a_reg;
    logic signed [LAB_W-1:0] b_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_LAB])
        begin
            l_reg <= flag_y_reg
                   ? ($signed(LAB_W'(f_reg[1])) * 32'sd116 - 32'sd16777216)
                   : $signed(LAB_W'(llin_reg));
            a_reg <= ($signed(LAB_W'(f_reg[0])) - $signed(LAB_W'(f_reg[1]))) * 32'sd500;
            b_reg <= ($signed(LAB_W'(f_reg[1])) - $signed(LAB_W'(f_reg[2]))) * 32'sd200;
        end
    end

    // Round half away from zero to FRAC_BITS, then clamp.
    function automatic logic signed [16:0] round_sat(
        input logic signed [LAB_W-1:0] v,
        input logic signed [16:0]      lo,
        input logic signed [16:0]      hi
    );
        logic              neg;
        logic [LAB_W:0]    mag;
        logic signed [LAB_W+1:0] r;
        neg = v < 0;
        mag = neg ? ((LAB_W+1)'(0) - (LAB_W+1)'(v)) : (LAB_W+1)'(v);
        mag = (mag + (LAB_W+1)'(1 << (SHIFT - 1))) >> SHIFT;
        r   = neg ? -$signed((LAB_W+2)'(mag)) : $signed((LAB_W+2)'(mag));
        if (r < (LAB_W+2)'(lo))
        begin
            r = (LAB_W+2)'(lo);
        end
        if (r > (LAB_W+2)'(hi))
        begin
            r = (LAB_W+2)'(hi);
        end
        return r[16:0];
    endfunction

    logic [14:0] lightness_reg;
    logic [15:0] green_red_reg;
    logic [15:0] blue_yellow_reg;
    logic signed [16:0] l_sat;
    logic signed [16:0] a_sat;
    logic signed [16:0] b_sat;

    always_comb
    begin
        l_sat = round_sat(l_reg, 17'sd0, 17'sd32767);
        a_sat = round_sat(a_reg, -17'sd32768, 17'sd32767);
        b_sat = round_sat(b_reg, -17'sd32768, 17'sd32767);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            lightness_reg   <= l_sat[14:0];
            green_red_reg   <= a_sat[15:0];
            blue_yellow_reg <= b_sat[15:0];
        end
    end

    assign m_tdata = {1'b0, blue_yellow_reg, green_red_reg, lightness_reg};

    // Input back-pressure only appears once every stage holds a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg && !m_tready))
        else $error("s_tready low while the pipeline has room");

    // The normalized matrix never exceeds the white point.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (t_reg[0] <= T_W'(1 << 28) && t_reg[1] <= T_W'(1 << 28)
                          && t_reg[2] <= T_W'(1 << 28)))
        else $error("normalized tristimulus above white");

    // Lightness stays within 0 to 100.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (lightness_reg <= 15'(L_MAX)))
        else $error("lightness above 100");

endmodule

// ===== dv/tb_rgb_to_lab_converter.sv =====
// Self-checking testbench for the streaming RGB to CIE L*a*b* converter.
`timescale 1ns / 100ps

module tb_rgb_to_lab_converter;

    localparam int FRAC = 8;
    localparam int SHIFT = 20 - FRAC;

    typedef struct packed {
        logic [14:0] lightness;
        logic [15:0] green_red;
        logic [15:0] blue_yellow;
    } lab_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    logic [23:0] pixel_queue[$];
    lab_t        lab_expected[$];
    int          error_count;
    int          checked_count;
    bit          calm;

    rgb_to_lab_converter #(.FRAC_BITS(FRAC)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // (v/255)^2.5 in Q28.
    function automatic longint unsigned gamma_expand(input logic [7:0] v);
        longint unsigned n;
        longint unsigned r;
        longint unsigned c;
        longint unsigned vv;
        vv = v;
        n = (vv << 56) / 255;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= n)
            begin
                r = c;
            end
        end
        return (vv * vv * r + 32512) / 65025;
    endfunction

    // Lab companding curve, Q28 in and Q20 out.
    function automatic longint lab_curve(input longint unsigned t);
        longint unsigned n;
        longint unsigned r;
        longint unsigned c;
        if (t > 2377264)
        begin
            n = t << 32;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c * c <= n)
                begin
                    r = c;
                end
            end
            return longint'(r);
        end
        return longint'(((510329 * t + (64'd1 << 23)) >> 24) + 144631);
    endfunction

    // Round Q20 to the output format, halves away from zero, then clamp.
    function automatic longint round_clamp(input longint v, input longint lo,
                                           input longint hi);
        longint unsigned mag;
        longint r;
        mag = (v < 0) ? longint'(-v) : v;
        if (SHIFT > 0)
        begin
            mag = (mag + (64'd1 << (SHIFT - 1))) >> SHIFT;
        end
        r = (v < 0) ? -longint'(mag) : longint'(mag);
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic lab_t predict_lab(input logic [23:0] px);
        longint unsigned lin[3];
        longint unsigned t[3];
        longint unsigned acc;
        longint fx, fy, fz, lq;
        longint unsigned mtx[3][3];
        lab_t res;
        mtx = '{'{28437, 24656, 12443}, '{13937, 46868, 4731}, '{1164, 7173, 57199}};
        for (int i = 0; i < 3; i++)
        begin
            lin[i] = gamma_expand(px[8*i +: 8]);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                acc += mtx[i][j] * lin[j];
            end
            t[i] = (acc + (64'd1 << 15)) >> 16;
        end
        fx = lab_curve(t[0]);
        fy = lab_curve(t[1]);
        fz = lab_curve(t[2]);
        if (t[1] > 2377264)
        begin
            lq = 116 * fy - (longint'(16) << 20);
        end
        else
        begin
            lq = longint'((59198669 * t[1] + (64'd1 << 23)) >> 24);
        end
        res.lightness   = 15'(round_clamp(lq, 0, 32767));
        res.green_red   = 16'(round_clamp(500 * (fx - fy), -32768, 32767));
        res.blue_yellow = 16'(round_clamp(200 * (fy - fz), -32768, 32767));
        return res;
    endfunction

    // Idle about 13 percent of cycles, except in calm stretches.
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 13);
    endfunction

    // Driver: one pixel per transaction, predicted when it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                lab_expected.push_back(predict_lab(s_tdata));
            end
            if (!s_tvalid || s_tready)
            begin
                if (pixel_queue.size() > 0 && !idle_now())
                begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        lab_t got;
        lab_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready)
            begin
                got.lightness   = m_tdata[14:0];
                got.green_red   = m_tdata[30:15];
                got.blue_yellow = m_tdata[46:31];
                if (lab_expected.size() == 0)
                begin
                    $error("result with no pixel outstanding: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = lab_expected.pop_front();
                    checked_count++;
                    if (got.lightness !== want.lightness)
                    begin
                        $error("lightness expected %0d actual %0d",
                               want.lightness, got.lightness);
                        error_count++;
                    end
                    if (got.green_red !== want.green_red)
                    begin
                        $error("green_red expected %0d actual %0d",
                               $signed(want.green_red), $signed(got.green_red));
                        error_count++;
                    end
                    if (got.blue_yellow !== want.blue_yellow)
                    begin
                        $error("blue_yellow expected %0d actual %0d",
                               $signed(want.blue_yellow), $signed(got.blue_yellow));
                        error_count++;
                    end
                    if (m_tdata[47] !== 1'b0)
                    begin
                        $error("pad bit expected 0 actual %b", m_tdata[47]);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [7:0] edge_vals[6];
        int mode;
        logic [7:0] ch[3];
        error_count = 0;
        checked_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: black, white, primaries, secondaries, dark-range and
        // near-white grays, single-channel extremes.
        edge_vals = '{8'd0, 8'd1, 8'd20, 8'd26, 8'd254, 8'd255};
        pixel_queue.push_back(24'h000000);
        pixel_queue.push_back(24'hFFFFFF);
        pixel_queue.push_back(24'h0000FF);
        pixel_queue.push_back(24'h00FF00);
        pixel_queue.push_back(24'hFF0000);
        pixel_queue.push_back(24'h00FFFF);
        pixel_queue.push_back(24'hFF00FF);
        pixel_queue.push_back(24'hFFFF00);
        foreach (edge_vals[k])
        begin
            pixel_queue.push_back({3{edge_vals[k]}});
        end
        pixel_queue.push_back(24'h010000);
        pixel_queue.push_back(24'h000001);
        pixel_queue.push_back(24'hFE01FE);
        pixel_queue.push_back(24'h01FE01);
        pixel_queue.push_back(24'hAA55AA);
        pixel_queue.push_back(24'h55AA55);

        // Random part, with a calm stretch in the middle.
        for (int n = 0; n < 1150; n++)
        begin
            mode = $urandom_range(9);
            for (int c = 0; c < 3; c++)
            begin
                if (mode < 2)
                begin
                    ch[c] = edge_vals[$urandom_range(5)];
                end
                else if (mode < 4)
                begin
                    ch[c] = 8'($urandom_range(40));
                end
                else
                begin
                    ch[c] = 8'($urandom);
                end
            end
            pixel_queue.push_back({ch[2], ch[1], ch[0]});
        end

        while (pixel_queue.size() > 600)
        begin
            @(posedge clk);
        end
        calm = 1'b1;
        while (pixel_queue.size() > 300)
        begin
            @(posedge clk);
        end
        calm = 1'b0;
        while (pixel_queue.size() > 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (lab_expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        $display("Converted %0d pixels: primaries, grays across the dark-range threshold,",
                 checked_count);
        $display("channel extremes and random colors, with stalls on both channels.");
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/rgblab_pkg.sv
src/rgblab_cbrt.sv
src/rgb_to_lab_converter.sv
dv/tb_rgb_to_lab_converter.sv
